@@ hdl/umsd_scan_pkg.sv @@
// Package for the USB mass storage descriptor scan.
// Holds the descriptor codes, the configuration register map and their widths.
// No dependencies; every other file of the block imports it.
package umsd_scan_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CAP_DEPTH  = 6;
  localparam int unsigned CAP_IDX_W  = 3;

  localparam logic [BYTE_W-1:0] DESC_INTERFACE = 8'd4;
  localparam logic [BYTE_W-1:0] DESC_ENDPOINT  = 8'd5;
  localparam logic [1:0]        XFER_BULK      = 2'd2;
  localparam logic [BYTE_W-1:0] MIN_DESC_LEN   = 8'd2;
  localparam logic [BYTE_W-1:0] FIRST_CAPTURED = 8'd2;

  localparam logic [BYTE_W-1:0] RST_MATCH_CLASS    = 8'd8;
  localparam logic [BYTE_W-1:0] RST_MATCH_SUBCLASS = 8'd6;
  localparam logic [BYTE_W-1:0] RST_MATCH_PROTOCOL = 8'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_CLASS    = 2'd0,
    CFG_MATCH_SUBCLASS = 2'd1,
    CFG_MATCH_PROTOCOL = 2'd2
  } cfg_idx_t;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

@@ hdl/usb_mass_storage_descriptor_scan.sv @@
// Top level of the USB mass storage descriptor scan.
// Walks a configuration descriptor set one byte per item; uses umsd_scan_pkg.
// The assertion checker in umsd_scan_checker.sv binds to this module.

// The block takes one descriptor byte per cycle and accepts a new byte in
// every cycle while the result register is free or being emptied. Each byte
// is handled by a single layer of compare and select logic that updates the
// walk registers; the byte flagged last loads the result register, so its
// result appears in the cycle after acceptance and the walk restarts with the
// next byte. Configuration writes are always accepted and take effect on
// the following byte.
module usb_mass_storage_descriptor_scan (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [umsd_scan_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [umsd_scan_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [umsd_scan_pkg::BYTE_W-1:0]      in_desc_byte,
  input  logic                                  in_last_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_interface_found,
  output logic [umsd_scan_pkg::BYTE_W-1:0]      out_bulk_in_address,
  output logic [umsd_scan_pkg::BYTE_W-1:0]      out_bulk_out_address,
  output logic [umsd_scan_pkg::BYTE_W-1:0]      out_endpoints_taken,
  output logic [umsd_scan_pkg::BYTE_W-1:0]      out_endpoint_limit,
  output logic                                  out_usable,
  output logic                                  out_stopped_early
);
  import umsd_scan_pkg::*;

  // Match registers.
  byte_t match_class_r, match_subclass_r, match_protocol_r;

  // Walk state.
  byte_t pos_r, pos_nxt;
  byte_t len_r, len_nxt;
  byte_t type_r, type_nxt;
  byte_t cap_r [CAP_DEPTH];
  byte_t cap_nxt [CAP_DEPTH];
  logic  halted_r, halted_nxt;
  logic  seen_r, seen_nxt;
  byte_t announced_r, announced_nxt;
  byte_t accepted_r, accepted_nxt;
  byte_t in_addr_r, in_addr_nxt;
  byte_t out_addr_r, out_addr_nxt;

  // Values after this byte, before the end-of-set clear.
  logic  seen_p, halted_p;
  byte_t announced_p, accepted_p, in_addr_p, out_addr_p;

  // Result register.
  logic  out_valid_r;
  logic  found_r, usable_r, stopped_r;
  byte_t res_in_r, res_out_r, res_taken_r, res_limit_r;

  logic  in_fire;
  logic  finish;
  logic  cap_hit;
  byte_t cap_off;
  byte_t type_eff;
  byte_t cap_eff [CAP_DEPTH];
  logic  [BYTE_W:0] pos_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_class_r    <= RST_MATCH_CLASS;
      match_subclass_r <= RST_MATCH_SUBCLASS;
      match_protocol_r <= RST_MATCH_PROTOCOL;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MATCH_CLASS:    match_class_r    <= cfg_data;
        CFG_MATCH_SUBCLASS: match_subclass_r <= cfg_data;
        CFG_MATCH_PROTOCOL: match_protocol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Offsets 2 to 7 of a descriptor are captured; the current byte is merged
  // in so that a descriptor ending on a captured offset sees it.
  assign cap_off  = pos_r - FIRST_CAPTURED;
  assign cap_hit  = !halted_r && (pos_r >= FIRST_CAPTURED) &&
                    (pos_r < FIRST_CAPTURED + BYTE_W'(CAP_DEPTH));
  assign type_eff = (pos_r == 8'd1) ? in_desc_byte : type_r;
  assign pos_inc  = {1'b0, pos_r} + 9'd1;

  always_comb begin
    for (int k = 0; k < CAP_DEPTH; k++) begin
      cap_eff[k] = (cap_hit && cap_off[CAP_IDX_W-1:0] == CAP_IDX_W'(k)) ?
                   in_desc_byte : cap_r[k];
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    halted_p    = halted_r;
    finish      = 1'b0;
    for (int k = 0; k < CAP_DEPTH; k++) cap_nxt[k] = cap_eff[k];

    if (!halted_r) begin
      if (pos_r == '0) begin
        if (!in_last_byte) begin
          if (in_desc_byte < MIN_DESC_LEN) begin
            halted_p = 1'b1;
          end else begin
            len_nxt = in_desc_byte;
            pos_nxt = 8'd1;
            for (int k = 0; k < CAP_DEPTH; k++) cap_nxt[k] = '0;
          end
        end
      end else begin
        type_nxt = type_eff;
        if (pos_inc == {1'b0, len_r}) begin
          finish  = 1'b1;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_inc[BYTE_W-1:0];
        end
      end
    end

    seen_p      = seen_r;
    announced_p = announced_r;
    accepted_p  = accepted_r;
    in_addr_p   = in_addr_r;
    out_addr_p  = out_addr_r;
    if (finish) begin
      if (type_eff == DESC_INTERFACE) begin
        if (cap_eff[3] == match_class_r && cap_eff[4] == match_subclass_r &&
            cap_eff[5] == match_protocol_r) begin
          seen_p      = 1'b1;
          announced_p = cap_eff[2];
          accepted_p  = '0;
        end else if (!seen_r) begin
          announced_p = '0;
        end
      end else if (type_eff == DESC_ENDPOINT && seen_r &&
                   accepted_r < announced_r && cap_eff[1][1:0] == XFER_BULK) begin
        if (cap_eff[0][BYTE_W-1]) in_addr_p  = cap_eff[0];
        else                      out_addr_p = cap_eff[0];
        accepted_p = accepted_r + 8'd1;
      end
    end

    // The byte flagged last closes the set: the walk starts again afresh.
    halted_nxt    = halted_p;
    seen_nxt      = seen_p;
    announced_nxt = announced_p;
    accepted_nxt  = accepted_p;
    in_addr_nxt   = in_addr_p;
    out_addr_nxt  = out_addr_p;
    if (in_last_byte) begin
      pos_nxt       = '0;
      halted_nxt    = 1'b0;
      seen_nxt      = 1'b0;
      announced_nxt = '0;
      accepted_nxt  = '0;
      in_addr_nxt   = '0;
      out_addr_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      halted_r    <= 1'b0;
      seen_r      <= 1'b0;
      announced_r <= '0;
      accepted_r  <= '0;
      in_addr_r   <= '0;
      out_addr_r  <= '0;
    end else if (in_fire) begin
      pos_r       <= pos_nxt;
      halted_r    <= halted_nxt;
      seen_r      <= seen_nxt;
      announced_r <= announced_nxt;
      accepted_r  <= accepted_nxt;
      in_addr_r   <= in_addr_nxt;
      out_addr_r  <= out_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      len_r  <= len_nxt;
      type_r <= type_nxt;
      for (int k = 0; k < CAP_DEPTH; k++) cap_r[k] <= cap_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      found_r     <= seen_p;
      res_in_r    <= in_addr_p;
      res_out_r   <= out_addr_p;
      res_taken_r <= accepted_p;
      res_limit_r <= announced_p;
      usable_r    <= seen_p && (in_addr_p != '0) && (out_addr_p != '0);
      stopped_r   <= halted_p;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_interface_found  = found_r;
  assign out_bulk_in_address  = res_in_r;
  assign out_bulk_out_address = res_out_r;
  assign out_endpoints_taken  = res_taken_r;
  assign out_endpoint_limit   = res_limit_r;
  assign out_usable           = usable_r;
  assign out_stopped_early    = stopped_r;

endmodule

@@ hdl/umsd_scan_checker.sv @@
// Port-level assertion checker for the USB mass storage descriptor scan.
// Depends on umsd_scan_pkg and is bound to usb_mass_storage_descriptor_scan.
module umsd_scan_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last_byte,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_interface_found,
  input logic [umsd_scan_pkg::BYTE_W-1:0]  out_bulk_in_address,
  input logic [umsd_scan_pkg::BYTE_W-1:0]  out_bulk_out_address,
  input logic [umsd_scan_pkg::BYTE_W-1:0]  out_endpoints_taken,
  input logic [umsd_scan_pkg::BYTE_W-1:0]  out_endpoint_limit,
  input logic                              out_usable
);
  import umsd_scan_pkg::*;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bulk_in_address) &&
      $stable(out_bulk_out_address) && $stable(out_endpoints_taken))
    else $error("result changed while stalled");

  // The last byte of a set produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> out_valid)
    else $error("no result after the last byte");

  a_taken_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_endpoints_taken <= out_endpoint_limit)
    else $error("more endpoints taken than announced");

  a_usable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_usable |-> out_interface_found &&
      out_bulk_in_address != '0 && out_bulk_out_address != '0)
    else $error("usable without interface and both addresses");

  // Without a matching interface nothing can have been collected.
  a_nothing_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_interface_found |-> out_endpoint_limit == '0 &&
      out_endpoints_taken == '0 && out_bulk_in_address == '0 &&
      out_bulk_out_address == '0)
    else $error("endpoint data without a matching interface");

endmodule

bind usb_mass_storage_descriptor_scan umsd_scan_checker u_umsd_scan_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .in_last_byte         (in_last_byte),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_interface_found  (out_interface_found),
  .out_bulk_in_address  (out_bulk_in_address),
  .out_bulk_out_address (out_bulk_out_address),
  .out_endpoints_taken  (out_endpoints_taken),
  .out_endpoint_limit   (out_endpoint_limit),
  .out_usable           (out_usable)
);
